// File: rtl/stpr_pkg.sv
// ============================================================================
// stpr_pkg - shared types, tables and functions of the scope trace renderer
// Sample scaling to pixel height and per-page stroke fill helpers.
// ============================================================================
package stpr_pkg;

    typedef logic [5:0] t_height;
    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_page;

    localparam logic [7:0] BYTE_ALL = 8'b11111111;
    localparam logic [7:0] BYTE_NONE = 8'b00000000;

    localparam logic SCOPE_FULL = 1'b0;
    localparam logic SCOPE_TITLE = 1'b1;

    localparam logic REG_SCOPE_MODE = 1'b0;
    localparam logic REG_HIGHLIGHT = 1'b1;

    // Partial page fill: lit pixels from the stroke top down to the page bottom.
    localparam t_byte STROKE_PART [8] = '{
        8'b00000000, 8'b10000000, 8'b11000000, 8'b11100000,
        8'b11110000, 8'b11111000, 8'b11111100, 8'b11111110
    };

    // Clamp to -64..63, offset to 0..127, scale for the active mode.
    function automatic t_height scale_sample(input logic signed [7:0] s, input logic mode);
        logic [6:0] u;
        logic [8:0] u3;
        begin
            if (s < -8'sd64) begin
                u = 7'd0;
            end else if (s > 8'sd63) begin
                u = 7'd127;
            end else begin
                u = 7'(s + 8'sd64);
            end
            u3 = {2'b00, u} + {1'b0, u, 1'b0};
            if (mode == SCOPE_TITLE) begin
                scale_sample = u3[8:3];
            end else begin
                scale_sample = u[6:1];
            end
        end
    endfunction

    // Pixels of one page for a column lit from height val down to the bottom.
    function automatic t_byte fill_from(input t_height val, input t_page page);
        t_page edge_page;
        begin
            edge_page = 3'd7 - val[5:3];
            if (page > edge_page) begin
                fill_from = BYTE_ALL;
            end else if (page < edge_page) begin
                fill_from = BYTE_NONE;
            end else begin
                fill_from = STROKE_PART[val[2:0]];
            end
        end
    endfunction

endpackage

// File: rtl/scope_trace_page_renderer.sv
// ============================================================================
// scope_trace_page_renderer - scope trace to display page bytes
// Scales one sample per column, draws the vertical stroke between the
// neighbor midpoints and emits the eight page bytes of each column.
// ============================================================================
//
//  channel   direction  handshake                        payload
//  sample    in         i_sample_valid / o_sample_stall  i_sample
//  result    out        o_result_valid / i_result_stall  o_column, o_page_byte_0..7,
//                                                        o_frame_end
//  config    in         APB psel/penable/pwrite, pready  paddr, pwdata, prdata
//
// One sample is taken per cycle while the sample side is not stalled. A
// sample enters the request register, and the page bytes are formed from it
// on the way into the result register. The last sample of a frame makes two
// results and holds the sample side while the request register sends its
// second column. The first sample of a frame makes no result. Reset clears
// the column count, neighbor heights, valid flags and configuration
// registers. A stall on the result side holds the result register, and
// the sample side stalls as soon as the request register cannot drain,
// and while it still has its second column to send.
module scope_trace_page_renderer #(
    parameter int COLUMNS = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_sample_valid,
    output logic              o_sample_stall,
    input  logic signed [7:0] i_sample,

    output logic              o_result_valid,
    input  logic              i_result_stall,
    output logic [6:0]        o_column,
    output logic [7:0]        o_page_byte_0,
    output logic [7:0]        o_page_byte_1,
    output logic [7:0]        o_page_byte_2,
    output logic [7:0]        o_page_byte_3,
    output logic [7:0]        o_page_byte_4,
    output logic [7:0]        o_page_byte_5,
    output logic [7:0]        o_page_byte_6,
    output logic [7:0]        o_page_byte_7,
    output logic              o_frame_end,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CW = $clog2(COLUMNS);
    localparam int CWX = (CW > 7) ? CW : 7;
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);

    // Configuration registers
    logic       r_scope_mode;
    logic [2:0] r_highlight;

    // Frame state
    logic [CW-1:0]      r_count;
    stpr_pkg::t_height  r_left;
    stpr_pkg::t_height  r_centre;

    // Request register: operands of one or two pending columns
    logic               r_s1_valid;
    logic               r_s1_two;
    logic               r_s1_sel;
    logic [CW-1:0]      r_s1_col;
    stpr_pkg::t_height  r_s1_l;
    stpr_pkg::t_height  r_s1_c;
    stpr_pkg::t_height  r_s1_h;

    // Result register
    logic               r_out_valid;
    logic [6:0]         r_out_col;
    stpr_pkg::t_byte    r_out_page [8];
    logic               r_out_last;

    logic               w_out_ready;
    logic               w_s1_take;
    logic               w_s1_done;
    logic               w_accept;
    logic               w_cfg_wr;
    stpr_pkg::t_height  w_h;

    // Selected column operands and the page math
    logic [CW-1:0]      w_col;
    logic [CWX-1:0]     w_col_ext;
    stpr_pkg::t_height  w_l;
    stpr_pkg::t_height  w_c;
    stpr_pkg::t_height  w_r;
    logic               w_last;
    stpr_pkg::t_height  w_mid_l;
    stpr_pkg::t_height  w_mid_r;
    stpr_pkg::t_height  w_hi;
    stpr_pkg::t_height  w_lo;
    stpr_pkg::t_height  w_hi_adj;
    stpr_pkg::t_height  w_lo_adj;
    stpr_pkg::t_byte    w_page [8];

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = 32'd0;
        unique case (paddr[2])
            stpr_pkg::REG_SCOPE_MODE: prdata = {31'd0, r_scope_mode};
            stpr_pkg::REG_HIGHLIGHT:  prdata = {29'd0, r_highlight};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scope_mode <= stpr_pkg::SCOPE_FULL;
            r_highlight  <= 3'd0;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                stpr_pkg::REG_SCOPE_MODE: r_scope_mode <= pwdata[0];
                stpr_pkg::REG_HIGHLIGHT:  r_highlight  <= pwdata[2:0];
                default:                  r_highlight  <= r_highlight;
            endcase
        end
    end

    // Handshake: the request register drains into the result register when
    // that register is empty or being taken; stall samples until the request
    // has sent its final column.
    assign w_out_ready    = !r_out_valid || !i_result_stall;
    assign w_s1_take      = r_s1_valid && w_out_ready;
    assign w_s1_done      = w_s1_take && (!r_s1_two || r_s1_sel);
    assign o_sample_stall = r_s1_valid && !w_s1_done;
    assign w_accept       = i_sample_valid && !o_sample_stall;

    assign w_h = stpr_pkg::scale_sample(i_sample, r_scope_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_left     <= '0;
            r_centre   <= '0;
            r_s1_valid <= 1'b0;
            r_s1_sel   <= 1'b0;
            r_s1_two   <= 1'b0;
        end else begin
            // Load a new request, else drop the drained one or advance to
            // its second column
            if (w_accept && (r_count != '0)) begin
                r_s1_valid <= 1'b1;
                r_s1_sel   <= 1'b0;
                r_s1_two   <= (r_count == LAST_COL);
            end else if (w_s1_done) begin
                r_s1_valid <= 1'b0;
            end else if (w_s1_take) begin
                r_s1_sel <= 1'b1;
            end
            if (w_accept) begin
                if (r_count == '0) begin
                    // First column is its own left neighbor; no result yet
                    r_left   <= w_h;
                    r_centre <= w_h;
                end else begin
                    r_left   <= r_centre;
                    r_centre <= w_h;
                end
                if (r_count == LAST_COL) begin
                    r_count <= '0;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // Request payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_accept && (r_count != '0)) begin
            r_s1_col <= r_count - 1'b1;
            r_s1_l   <= r_left;
            r_s1_c   <= r_centre;
            r_s1_h   <= w_h;
        end
    end

    // Second column of a frame's last request: the last column, right
    // neighbor clamped to itself.
    always_comb begin
        if (r_s1_sel) begin
            w_col  = r_s1_col + 1'b1;
            w_l    = r_s1_c;
            w_c    = r_s1_h;
            w_r    = r_s1_h;
            w_last = 1'b1;
        end else begin
            w_col  = r_s1_col;
            w_l    = r_s1_l;
            w_c    = r_s1_c;
            w_r    = r_s1_h;
            w_last = 1'b0;
        end
    end

    assign w_col_ext = CWX'(w_col);
    assign w_mid_l   = 6'(({1'b0, w_l} + {1'b0, w_c}) >> 1);
    assign w_mid_r   = 6'(({1'b0, w_r} + {1'b0, w_c}) >> 1);

    always_comb begin
        w_hi = w_c;
        w_lo = w_c;
        if (w_mid_l > w_hi) w_hi = w_mid_l;
        if (w_mid_l < w_lo) w_lo = w_mid_l;
        if (w_mid_r > w_hi) w_hi = w_mid_r;
        if (w_mid_r < w_lo) w_lo = w_mid_r;
        w_hi_adj = w_hi;
        w_lo_adj = w_lo;
        // Widen a flat stroke by one pixel
        if (w_lo == w_hi) begin
            if (w_hi != '0) begin
                w_lo_adj = w_lo - 1'b1;
            end else begin
                w_hi_adj = w_hi + 1'b1;
            end
        end
    end

    always_comb begin
        for (int p = 0; p < 8; p++) begin
            if ((r_scope_mode == stpr_pkg::SCOPE_TITLE) && (p < 2)) begin
                w_page[p] = stpr_pkg::BYTE_NONE;
            end else begin
                w_page[p] = stpr_pkg::fill_from(w_hi_adj, 3'(p))
                          & ~stpr_pkg::fill_from(w_lo_adj, 3'(p));
            end
            // Invert the highlighted page pair
            if ((r_highlight != 3'd0) && (3'(p >> 1) + 3'd1 == r_highlight)) begin
                w_page[p] = ~w_page[p];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_s1_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_take) begin
            r_out_col  <= w_col_ext[6:0];
            r_out_page <= w_page;
            r_out_last <= w_last;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_column       = r_out_col;
    assign o_page_byte_0  = r_out_page[0];
    assign o_page_byte_1  = r_out_page[1];
    assign o_page_byte_2  = r_out_page[2];
    assign o_page_byte_3  = r_out_page[3];
    assign o_page_byte_4  = r_out_page[4];
    assign o_page_byte_5  = r_out_page[5];
    assign o_page_byte_6  = r_out_page[6];
    assign o_page_byte_7  = r_out_page[7];
    assign o_frame_end    = r_out_last;

endmodule
